/* hw/rtl/lfpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants for the PD line follower
// Register addresses, result modes, configuration and state records.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SENSOR_W = 10;
    localparam int unsigned SPEED_W  = 8;
    localparam int unsigned IVAL_W   = 16;
    localparam int unsigned GAIN_W   = 8;
    localparam int unsigned ERR_W    = 11;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 16;
    // Width of the PD sum; kp*e + kd*d stays within 21 signed bits.
    localparam int unsigned PD_W     = 22;

    // Speed drop applied to both motors at an intersection.
    localparam logic [SPEED_W-1:0] CROSS_SLOWDOWN = 8'd25;

    localparam logic [SENSOR_W-1:0] RST_SET_POINT       = 10'd512;
    localparam logic [SPEED_W-1:0]  RST_FULL_SPEED      = 8'd255;
    localparam logic [IVAL_W-1:0]   RST_UPDATE_INTERVAL = 16'd10;
    localparam logic [GAIN_W-1:0]   RST_KP_HALVES       = 8'd3;
    localparam logic [GAIN_W-1:0]   RST_KD_HALVES       = 8'd10;
    localparam logic [SENSOR_W-1:0] RST_LOST_THRESHOLD  = 10'd103;
    localparam logic [SENSOR_W-1:0] RST_CROSS_THRESHOLD = 10'd972;

    typedef enum logic [ADDR_W-1:0] {
        CFG_SET_POINT       = 3'd0,
        CFG_FULL_SPEED      = 3'd1,
        CFG_UPDATE_INTERVAL = 3'd2,
        CFG_KP_HALVES       = 3'd3,
        CFG_KD_HALVES       = 3'd4,
        CFG_LOST_THRESHOLD  = 3'd5,
        CFG_CROSS_THRESHOLD = 3'd6
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MODE_NO_UPDATE = 2'd0,
        MODE_LOST      = 2'd1,
        MODE_CROSS     = 2'd2,
        MODE_TRACK     = 2'd3
    } t_mode;

    typedef struct packed {
        logic [SENSOR_W-1:0] set_point;
        logic [SPEED_W-1:0]  full_speed;
        logic [IVAL_W-1:0]   update_interval_ms;
        logic [GAIN_W-1:0]   kp_halves;
        logic [GAIN_W-1:0]   kd_halves;
        logic [SENSOR_W-1:0] lost_threshold;
        logic [SENSOR_W-1:0] cross_threshold;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]       last_update_time;
        logic signed [ERR_W-1:0] last_error;
        logic                    left_fwd;
        logic                    right_fwd;
        logic [SPEED_W-1:0]      left_speed;
        logic [SPEED_W-1:0]      right_speed;
    } t_state;

    typedef struct packed {
        logic               updated;
        t_mode              mode;
        logic               left_forward;
        logic               right_forward;
        logic [SPEED_W-1:0] left_speed;
        logic [SPEED_W-1:0] right_speed;
    } t_result;

endpackage

/* hw/rtl/lfpd_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_ifs: handshake channels of the PD line follower
// Sensor sample channel, motor command channel and register write channel.
// ----------------------------------------------------------------------------
interface lfpd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [9:0]  sensor_value;

    modport source (output valid, output now_ms, output sensor_value, input ready);
    modport sink   (input valid, input now_ms, input sensor_value, output ready);
endinterface

interface lfpd_out_if;
    logic       valid;
    logic       ready;
    logic       updated;
    logic [1:0] mode;
    logic       left_forward;
    logic       right_forward;
    logic [7:0] left_speed;
    logic [7:0] right_speed;

    modport source (output valid, output updated, output mode, output left_forward,
                    output right_forward, output left_speed, output right_speed,
                    input ready);
    modport sink   (input valid, input updated, input mode, input left_forward,
                    input right_forward, input left_speed, input right_speed,
                    output ready);
endinterface

interface lfpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [15:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

/* hw/rtl/lfpd_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_cfg_regs: configuration register file
// Holds the seven control registers; writes are always accepted.
// ----------------------------------------------------------------------------
module lfpd_cfg_regs
    import lfpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0]     i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_point          <= RST_SET_POINT;
            r_cfg.full_speed         <= RST_FULL_SPEED;
            r_cfg.update_interval_ms <= RST_UPDATE_INTERVAL;
            r_cfg.kp_halves          <= RST_KP_HALVES;
            r_cfg.kd_halves          <= RST_KD_HALVES;
            r_cfg.lost_threshold     <= RST_LOST_THRESHOLD;
            r_cfg.cross_threshold    <= RST_CROSS_THRESHOLD;
        end else if (i_wr_en) begin
            case (t_cfg_addr'(i_wr_addr))
                CFG_SET_POINT:       r_cfg.set_point          <= i_wr_data[SENSOR_W-1:0];
                CFG_FULL_SPEED:      r_cfg.full_speed         <= i_wr_data[SPEED_W-1:0];
                CFG_UPDATE_INTERVAL: r_cfg.update_interval_ms <= i_wr_data[IVAL_W-1:0];
                CFG_KP_HALVES:       r_cfg.kp_halves          <= i_wr_data[GAIN_W-1:0];
                CFG_KD_HALVES:       r_cfg.kd_halves          <= i_wr_data[GAIN_W-1:0];
                CFG_LOST_THRESHOLD:  r_cfg.lost_threshold     <= i_wr_data[SENSOR_W-1:0];
                CFG_CROSS_THRESHOLD: r_cfg.cross_threshold    <= i_wr_data[SENSOR_W-1:0];
                default: begin
                    // Addresses past the register list are ignored.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/lfpd_law.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_law: PD steering law
// Decides whether a sample triggers an update, classifies it and mixes the
// PD correction into motor directions and speeds.
// ----------------------------------------------------------------------------
module lfpd_law
    import lfpd_pkg::*;
(
    input  t_cfg                i_cfg,
    input  t_state              i_state,
    input  logic [TIME_W-1:0]   i_now_ms,
    input  logic [SENSOR_W-1:0] i_sensor,
    output t_state              o_state,
    output t_result             o_result
);

    logic [TIME_W-1:0]       elapsed;
    logic                    do_update;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   deriv;
    logic signed [PD_W-1:0]  kp_x;
    logic signed [PD_W-1:0]  kd_x;
    logic signed [PD_W-1:0]  pd;
    logic signed [PD_W-1:0]  m1;
    logic signed [PD_W-1:0]  m2;
    logic signed [PD_W-1:0]  m4;
    logic signed [PD_W-1:0]  over_pos;
    logic signed [PD_W-1:0]  over_neg;
    logic signed [PD_W-1:0]  mid_pos;
    logic signed [PD_W-1:0]  mid_neg;
    logic [SPEED_W-1:0]      cross_speed;
    t_state                  nxt;

    always_comb begin
        elapsed   = i_now_ms - i_state.last_update_time;
        do_update = elapsed > {{(TIME_W-IVAL_W){1'b0}}, i_cfg.update_interval_ms};

        err   = signed'({1'b0, i_sensor}) - signed'({1'b0, i_cfg.set_point});
        deriv = ERR_W'(0) + ({err[ERR_W-1], err} - {i_state.last_error[ERR_W-1],
                                                    i_state.last_error});
        kp_x  = signed'({{(PD_W-GAIN_W){1'b0}}, i_cfg.kp_halves});
        kd_x  = signed'({{(PD_W-GAIN_W){1'b0}}, i_cfg.kd_halves});
        pd    = kp_x * PD_W'(err) + kd_x * PD_W'(deriv);

        m1 = signed'({{(PD_W-SPEED_W){1'b0}}, i_cfg.full_speed});
        m2 = m1 <<< 1;
        m4 = m1 <<< 2;

        // All four differences are nonnegative where they are used, so the
        // right shift by one is truncation toward zero.
        over_pos = pd - m2;
        over_neg = -pd - m2;
        mid_pos  = m2 - pd;
        mid_neg  = m2 + pd;

        cross_speed = (i_cfg.full_speed > CROSS_SLOWDOWN) ?
                      (i_cfg.full_speed - CROSS_SLOWDOWN) : '0;

        nxt = i_state;
        o_result.updated = 1'b0;
        o_result.mode    = MODE_NO_UPDATE;

        if (do_update) begin
            o_result.updated     = 1'b1;
            nxt.last_update_time = i_now_ms;
            if (i_sensor < i_cfg.lost_threshold) begin
                o_result.mode   = MODE_LOST;
                nxt.left_speed  = '0;
                nxt.right_speed = '0;
            end else if (i_sensor > i_cfg.cross_threshold) begin
                o_result.mode   = MODE_CROSS;
                nxt.left_speed  = cross_speed;
                nxt.right_speed = cross_speed;
            end else begin
                o_result.mode  = MODE_TRACK;
                nxt.last_error = err;
                if (pd > m2) begin
                    nxt.left_fwd    = 1'b1;
                    nxt.right_fwd   = 1'b0;
                    nxt.left_speed  = i_cfg.full_speed;
                    nxt.right_speed = (pd < m4) ? over_pos[SPEED_W:1] : i_cfg.full_speed;
                end else if (pd < -m2) begin
                    nxt.left_fwd    = 1'b0;
                    nxt.right_fwd   = 1'b1;
                    nxt.right_speed = i_cfg.full_speed;
                    nxt.left_speed  = (pd > -m4) ? over_neg[SPEED_W:1] : i_cfg.full_speed;
                end else begin
                    nxt.left_fwd  = 1'b1;
                    nxt.right_fwd = 1'b1;
                    if (pd > 0) begin
                        nxt.left_speed  = i_cfg.full_speed;
                        nxt.right_speed = mid_pos[SPEED_W:1];
                    end else begin
                        nxt.left_speed  = mid_neg[SPEED_W:1];
                        nxt.right_speed = i_cfg.full_speed;
                    end
                end
            end
        end

        o_result.left_forward  = nxt.left_fwd;
        o_result.right_forward = nxt.right_fwd;
        o_result.left_speed    = nxt.left_speed;
        o_result.right_speed   = nxt.right_speed;
        o_state                = nxt;
    end

endmodule

/* hw/rtl/line_follow_pd_steering_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pd_steering_top: PD line follower for a differential drive
// Takes timestamped line sensor samples and returns one motor command
// transaction per sample.
// ----------------------------------------------------------------------------
//
//   Channel   Port    Dir  Transaction carries
//   -------   -----   ---  --------------------------------------------------
//   sample    i_in    in   now_ms, sensor_value
//   command   o_out   out  updated, mode, left/right_forward, left/right_speed
//   config    i_cfg   in   addr (register number 0..6), data (low bits used)
//
// Each sample is captured in an input register; the steering law then runs
// on it in one pass and the command lands in the output register together
// with the updated controller state. A new sample can be taken every cycle
// while the command sink is ready. The controller state is committed at the
// same edge the command is registered, so a sample that follows directly sees
// the state left by its predecessor. When the command sink stalls, the output
// register holds and the input register fills; i_in.ready drops only when both
// are occupied. Synchronous active-low reset restores register defaults,
// clears the timing and error state, sets both motors forward at speed zero
// and empties both registers. Config writes are always accepted.
//
module line_follow_pd_steering_top
    import lfpd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfpd_in_if.sink      i_in,
    lfpd_out_if.source   o_out,
    lfpd_cfg_if.sink     i_cfg
);

    t_cfg                cfg;
    t_state              r_state;
    t_state              n_state;
    t_result             n_result;
    t_result             r_result;

    logic                r_in_valid;
    logic [TIME_W-1:0]   r_now_ms;
    logic [SENSOR_W-1:0] r_sensor;
    logic                r_out_valid;
    logic                advance;
    logic                in_take;

    // Register file; the write port never stalls.
    assign i_cfg.ready = 1'b1;

    lfpd_cfg_regs u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg.valid),
        .i_wr_addr (i_cfg.addr),
        .i_wr_data (i_cfg.data),
        .o_cfg     (cfg)
    );

    // The captured sample moves on when the output register is free or is
    // being emptied in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now_ms <= i_in.now_ms;
            r_sensor <= i_in.sensor_value;
        end
    end

    lfpd_law u_law (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_now_ms (r_now_ms),
        .i_sensor (r_sensor),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Controller state only changes when a sample is turned into a command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_update_time <= '0;
            r_state.last_error       <= '0;
            r_state.left_fwd         <= 1'b1;
            r_state.right_fwd        <= 1'b1;
            r_state.left_speed       <= '0;
            r_state.right_speed      <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.updated       = r_result.updated;
    assign o_out.mode          = r_result.mode;
    assign o_out.left_forward  = r_result.left_forward;
    assign o_out.right_forward = r_result.right_forward;
    assign o_out.left_speed    = r_result.left_speed;
    assign o_out.right_speed   = r_result.right_speed;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the PD line follower steering block
// Timestamped sensor samples go in on the sample channel, and every motor
// command transaction that comes back is compared, field by field, with a
// command predicted here from an independent model of the steering law.
// Directed tests cover the reset state, the PD saturation bounds, the
// threshold classes and the update interval. Randomized traffic under
// several register settings follows, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
    import lfpd_pkg::*;

    // A run with no transaction on any channel for this many cycles has hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    // The block registers the sample and then the command, so the pipeline
    // is two deep. A few more cycles are allowed before a register write.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned REPORT_LIMIT = 10;

    logic i_clk;
    logic i_rst_n;

    lfpd_in_if  in_if ();
    lfpd_out_if out_if ();
    lfpd_cfg_if cfg_if ();

    line_follow_pd_steering_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 10 ns clock period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Steering model. It keeps its own copy of the registers and of the
    // controller state and is advanced once per accepted sample transaction.
    // ------------------------------------------------------------------------
    t_cfg                    steer_cfg;
    logic [TIME_W-1:0]       ctl_last_time;
    logic signed [ERR_W-1:0] ctl_last_err;
    logic                    ctl_left_fwd;
    logic                    ctl_right_fwd;
    logic [SPEED_W-1:0]      ctl_left_spd;
    logic [SPEED_W-1:0]      ctl_right_spd;

    // Commands predicted for accepted samples, oldest first.
    t_result pending_cmds[$];

    int unsigned fail_count;
    int unsigned quiet_cycles;
    logic [TIME_W-1:0] stim_now;
    bit rst_done;
    // While set, neither side inserts gaps, so back-to-back traffic is seen.
    bit steady_flow;

    // Advances the model by one sample and returns the command it causes.
    function automatic t_result steer_predict(input logic [TIME_W-1:0] now,
                                              input logic [SENSOR_W-1:0] sensor);
        t_result cmd;
        logic [TIME_W-1:0] elapsed;
        int m, sv, sp, e, d, p;
        elapsed = now - ctl_last_time;
        cmd.updated = 1'b0;
        cmd.mode = MODE_NO_UPDATE;
        // The elapsed time wraps modulo 2^32 and must be strictly larger.
        if (elapsed > {16'd0, steer_cfg.update_interval_ms}) begin
            cmd.updated = 1'b1;
            ctl_last_time = now;
            // The lost test wins when the two thresholds overlap.
            if (sensor < steer_cfg.lost_threshold) begin
                cmd.mode = MODE_LOST;
                ctl_left_spd = '0;
                ctl_right_spd = '0;
            end else if (sensor > steer_cfg.cross_threshold) begin
                cmd.mode = MODE_CROSS;
                ctl_left_spd = (steer_cfg.full_speed > CROSS_SLOWDOWN) ?
                               steer_cfg.full_speed - CROSS_SLOWDOWN : '0;
                ctl_right_spd = ctl_left_spd;
            end else begin
                // All PD arithmetic is in halves; speeds are halved at the end
                // and every halved quantity is nonnegative.
                m = steer_cfg.full_speed;
                sv = sensor;
                sp = steer_cfg.set_point;
                e = sv - sp;
                d = e - int'(ctl_last_err);
                p = int'(steer_cfg.kp_halves) * e + int'(steer_cfg.kd_halves) * d;
                ctl_last_err = e[ERR_W-1:0];
                cmd.mode = MODE_TRACK;
                if (p > 2 * m) begin
                    ctl_left_fwd = 1'b1;
                    ctl_right_fwd = 1'b0;
                    ctl_left_spd = 8'(m);
                    ctl_right_spd = (p < 4 * m) ? 8'((p - 2 * m) / 2) : 8'(m);
                end else if (p < -2 * m) begin
                    ctl_left_fwd = 1'b0;
                    ctl_right_fwd = 1'b1;
                    ctl_right_spd = 8'(m);
                    ctl_left_spd = (p > -4 * m) ? 8'((-p - 2 * m) / 2) : 8'(m);
                end else begin
                    // Exactly plus or minus full scale stays in this band.
                    ctl_left_fwd = 1'b1;
                    ctl_right_fwd = 1'b1;
                    if (p > 0) begin
                        ctl_left_spd = 8'(m);
                        ctl_right_spd = 8'((2 * m - p) / 2);
                    end else begin
                        ctl_left_spd = 8'((2 * m + p) / 2);
                        ctl_right_spd = 8'(m);
                    end
                end
            end
        end
        // Every command reports the motor state now applied.
        cmd.left_forward = ctl_left_fwd;
        cmd.right_forward = ctl_right_fwd;
        cmd.left_speed = ctl_left_spd;
        cmd.right_speed = ctl_right_spd;
        return cmd;
    endfunction

    // Random gap before the next transaction: mostly none, some short and a
    // few long ones.
    function automatic int pick_gap();
        int r;
        if (steady_flow) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Sample channel driver. The expected command is produced at the edge
    // where the sample transaction is accepted. Valid stays high into the
    // next call unless a gap is drawn, so it is never lowered and raised in
    // one time step.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [SENSOR_W-1:0] s);
        int gap;
        in_if.valid <= 1'b1;
        in_if.now_ms <= t;
        in_if.sensor_value <= s;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        pending_cmds.push_back(steer_predict(t, s));
        stim_now = t;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends a sample a given number of milliseconds after the previous one.
    task automatic step(input int unsigned dt, input int sensor);
        send_sample(stim_now + dt, 10'(sensor));
    endtask

    // Stops the sample stream and waits until every command has come back,
    // then lets the pipeline go quiet.
    task automatic drain_commands();
        in_if.valid <= 1'b0;
        while (pending_cmds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; valid is dropped for a cycle after it so
    // that consecutive writes never collide in one time step.
    task automatic write_reg(input t_cfg_addr addr, input logic [DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr <= addr;
        cfg_if.data <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        // Only the low bits of the write data reach each register.
        case (addr)
            CFG_SET_POINT:       steer_cfg.set_point = data[SENSOR_W-1:0];
            CFG_FULL_SPEED:      steer_cfg.full_speed = data[SPEED_W-1:0];
            CFG_UPDATE_INTERVAL: steer_cfg.update_interval_ms = data[IVAL_W-1:0];
            CFG_KP_HALVES:       steer_cfg.kp_halves = data[GAIN_W-1:0];
            CFG_KD_HALVES:       steer_cfg.kd_halves = data[GAIN_W-1:0];
            CFG_LOST_THRESHOLD:  steer_cfg.lost_threshold = data[SENSOR_W-1:0];
            CFG_CROSS_THRESHOLD: steer_cfg.cross_threshold = data[SENSOR_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites all seven registers once the block is idle. Unused upper data
    // bits carry random junk, which the block must ignore.
    task automatic set_config(input int sp, input int ms, input int iv, input int kp,
                              input int kd, input int lo, input int cr);
        logic [DATA_W-1:0] junk;
        drain_commands();
        junk = 16'($urandom);
        write_reg(CFG_SET_POINT, {junk[15:10], 10'(sp)});
        write_reg(CFG_FULL_SPEED, {junk[15:8], 8'(ms)});
        write_reg(CFG_UPDATE_INTERVAL, 16'(iv));
        write_reg(CFG_KP_HALVES, {junk[7:0], 8'(kp)});
        write_reg(CFG_KD_HALVES, {junk[9:2], 8'(kd)});
        write_reg(CFG_LOST_THRESHOLD, {junk[5:0], 10'(lo)});
        write_reg(CFG_CROSS_THRESHOLD, {junk[11:6], 10'(cr)});
    endtask

    // ------------------------------------------------------------------------
    // Command channel: random backpressure, with stretches of none.
    // ------------------------------------------------------------------------
    initial begin : sink_stall
        int n;
        out_if.ready <= 1'b0;
        wait (rst_done);
        forever begin
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Every command transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_commands
        t_result seen;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.updated = out_if.updated;
            seen.mode = t_mode'(out_if.mode);
            seen.left_forward = out_if.left_forward;
            seen.right_forward = out_if.right_forward;
            seen.left_speed = out_if.left_speed;
            seen.right_speed = out_if.right_speed;
            if (pending_cmds.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("%0t: command with no sample pending: upd=%0d mode=%0d",
                             $realtime, seen.updated, seen.mode);
                end
            end else begin
                want = pending_cmds.pop_front();
                if (seen.updated !== want.updated || seen.mode !== want.mode ||
                    seen.left_forward !== want.left_forward ||
                    seen.right_forward !== want.right_forward ||
                    seen.left_speed !== want.left_speed ||
                    seen.right_speed !== want.right_speed) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch, exp upd=%0d mode=%0d fwd=%0d/%0d spd=%0d/%0d",
                                 $realtime, want.updated, want.mode, want.left_forward,
                                 want.right_forward, want.left_speed, want.right_speed);
                        $display("%0t:           got upd=%0d mode=%0d fwd=%0d/%0d spd=%0d/%0d",
                                 $realtime, seen.updated, seen.mode, seen.left_forward,
                                 seen.right_forward, seen.left_speed, seen.right_speed);
                    end
                end
            end
        end
    end

    // Hang detection: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers: interval edge, first update, both extremes of the
    // sensor, the threshold values themselves and time wrapping past 2^32.
    task automatic test_reset_defaults();
        send_sample(32'd5, 10'd512);          // too early, reset state shown
        send_sample(32'd10, 10'd512);         // equal to the interval, no update
        send_sample(32'd11, 10'd512);         // centered, both at full speed
        send_sample(32'd30, 10'd0);           // line lost
        send_sample(32'd50, 10'd1023);        // intersection, slowed down
        send_sample(32'hFFFF_FFF0, 10'd103);  // lost threshold itself tracks
        send_sample(32'd3, 10'd972);          // elapsed time wraps to 19
        step(11, 102);
        step(11, 973);
    endtask

    // Proportional term only, with gains chosen so that the PD value lands
    // exactly on and next to twice and four times full speed, on both sides,
    // including odd values that must truncate. Then a pure derivative kick.
    task automatic test_pd_bounds();
        set_config(512, 100, 0, 2, 0, 103, 972);
        step(1, 612);   // exactly +2M stays in the middle band
        step(1, 614);
        step(1, 711);
        step(1, 712);   // exactly +4M saturates
        step(1, 412);   // exactly -2M stays in the middle band
        step(1, 313);
        step(1, 312);   // exactly -4M saturates
        set_config(512, 100, 0, 1, 0, 103, 972);
        step(1, 513);
        step(1, 511);
        step(1, 713);
        set_config(512, 200, 0, 0, 255, 103, 972);
        step(1, 600);
        step(1, 400);
    endtask

    // Overlapping thresholds, the intersection speed floor and zero speed.
    task automatic test_thresholds();
        set_config(512, 25, 0, 3, 10, 600, 400);
        step(1, 500);   // both tests met, lost wins
        step(1, 700);   // intersection at full speed 25 gives zero
        step(1, 600);
        set_config(512, 26, 0, 3, 10, 103, 972);
        step(1, 1023);
        set_config(512, 0, 0, 3, 10, 103, 972);
        step(1, 700);
    endtask

    // Largest and smallest update intervals.
    task automatic test_interval_extremes();
        set_config(512, 255, 65535, 3, 10, 103, 972);
        step(65535, 520);
        step(65536, 520);
        set_config(512, 255, 0, 3, 10, 103, 972);
        step(0, 530);
        step(1, 530);
    endtask

    // Random samples: time mostly advances around the interval, sometimes
    // jumps anywhere or steps back; readings mostly sit near the set point
    // and otherwise near the thresholds, anywhere, or at the extremes.
    task automatic run_traffic(input int n_items);
        int r;
        int sv;
        logic [TIME_W-1:0] t;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 49) begin
                steady_flow = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 149) == 0) begin
                drain_commands();
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                t = stim_now + $urandom_range(0, 2 * steer_cfg.update_interval_ms + 2);
            end else if (r < 85) begin
                t = stim_now + $urandom_range(0, 3);
            end else if (r < 95) begin
                t = $urandom;
            end else begin
                t = stim_now - $urandom_range(0, 5);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                sv = steer_cfg.set_point + $urandom_range(0, 240) - 120;
            end else if (r < 75) begin
                sv = $urandom_range(0, 1023);
            end else if (r < 85) begin
                sv = steer_cfg.lost_threshold + $urandom_range(0, 4) - 2;
            end else if (r < 95) begin
                sv = steer_cfg.cross_threshold + $urandom_range(0, 4) - 2;
            end else begin
                sv = $urandom_range(0, 1) ? 1023 : 0;
            end
            if (sv < 0) begin
                sv = 0;
            end
            if (sv > 1023) begin
                sv = 1023;
            end
            send_sample(t, 10'(sv));
        end
    endtask

    // Several register settings: the reset values, both extremes of every
    // register, then random ones with mostly short intervals and modest gains.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_config(512, 255, 10, 3, 10, 103, 972);
                1: set_config(1023, 255, 0, 255, 255, 0, 1023);
                2: set_config(0, 0, 65535, 0, 0, 1023, 0);
                default: set_config($urandom_range(0, 1023), $urandom_range(0, 255),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 40),
                                    $urandom_range(0, 12), $urandom_range(0, 40),
                                    $urandom_range(0, 300), $urandom_range(700, 1023));
            endcase
            steady_flow = (phase == 1);
            run_traffic(160);
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.now_ms <= '0;
        in_if.sensor_value <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.addr <= CFG_SET_POINT;
        cfg_if.data <= '0;
        steady_flow = 1'b0;
        fail_count = 0;
        quiet_cycles = 0;
        stim_now = '0;
        steer_cfg = '{set_point: RST_SET_POINT, full_speed: RST_FULL_SPEED,
                      update_interval_ms: RST_UPDATE_INTERVAL,
                      kp_halves: RST_KP_HALVES, kd_halves: RST_KD_HALVES,
                      lost_threshold: RST_LOST_THRESHOLD,
                      cross_threshold: RST_CROSS_THRESHOLD};
        ctl_last_time = '0;
        ctl_last_err = '0;
        ctl_left_fwd = 1'b1;
        ctl_right_fwd = 1'b1;
        ctl_left_spd = '0;
        ctl_right_spd = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_pd_bounds();
        test_thresholds();
        test_interval_extremes();
        test_random_traffic();

        // The watchdog bounds this wait if commands stop coming.
        drain_commands();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
